// ----- rtl/aescbc_pkg.sv -----
// Shared types, register indexes and AES byte tables for the CBC codec.
package aescbc_pkg;

   typedef logic [7:0] byte_tbl_type [256];

   localparam int BLOCK_BITS = 128;
   localparam int ROUNDS     = 10;
   localparam int NUM_KEYS   = ROUNDS + 1;

   localparam logic [2:0] REG_DIRECTION = 3'd0;
   localparam logic [2:0] REG_KEY_HIGH  = 3'd1;
   localparam logic [2:0] REG_KEY_LOW   = 3'd2;
   localparam logic [2:0] REG_IV_HIGH   = 3'd3;
   localparam logic [2:0] REG_IV_LOW    = 3'd4;

   localparam logic [7:0] SBOX_AFFINE     = 8'h63;
   localparam logic [7:0] INV_SBOX_AFFINE = 8'h05;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x   = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x;
         x = xtime(x);
      end
      return acc;
   endfunction

   function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
      logic [15:0] d;
      d = {x, x} << n;
      return d[15:8];
   endfunction

   // Multiplicative inverse as a^254, zero maps to zero.
   function automatic logic [7:0] gf_inv(input logic [7:0] a);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h01;
      p = a;
      for (int k = 1; k < 8; k++) begin
         p = gmul(p, p);
         r = gmul(r, p);
      end
      return r;
   endfunction

   function automatic byte_tbl_type build_sbox();
      byte_tbl_type t;
      logic [7:0]   b;
      for (int i = 0; i < 256; i++) begin
         b = gf_inv(8'(i));
         t[i] = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ SBOX_AFFINE;
      end
      return t;
   endfunction

   function automatic byte_tbl_type build_inv_sbox();
      byte_tbl_type t;
      logic [7:0]   x;
      for (int i = 0; i < 256; i++) begin
         x = 8'(i);
         t[i] = gf_inv(rotl(x, 1) ^ rotl(x, 3) ^ rotl(x, 6) ^ INV_SBOX_AFFINE);
      end
      return t;
   endfunction

   localparam byte_tbl_type SBOX     = build_sbox();
   localparam byte_tbl_type INV_SBOX = build_inv_sbox();

endpackage

// ----- rtl/aes128_cbc_codec_pkcs_pad_top.sv -----
// Top level of the AES-128 CBC codec with PKCS#7 padding.
//
// Channels: req_* carries one 16-byte block per transfer with its byte count
// (tdata), first-block flag (tuser) and end-of-message flag (tlast). rsp_*
// returns result blocks: data and valid-byte count in tdata, end of message
// in tlast, length error in tuser. csr_* writes direction, key and IV; it is
// always ready and must only be used while the codec is idle.
// Sequencing: one shared round unit runs one AES round per cycle; a block
// passes accept, load, ten rounds, finish and output, and the first block
// after a key write first runs ten key schedule steps. A full final encrypt
// block yields a second, padding block. A length error skips the rounds and
// goes straight to output.
// req_tready is high only while the sequencer waits for a block, so a new
// block is taken only once the last one is handed to the output register.
// Reset clears direction, key, IV, chain value and the key-valid flag.
// A stalled result is held in the output register; the next block may be
// taken meanwhile, and the sequencer holds before output until it frees up.
module aes128_cbc_codec_pkcs_pad_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // 3'b0, byte_count, block_low, block_high
   input  logic         req_tuser,  // first_block
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,  // 3'b0, result_bytes, result_low, result_high
   output logic         rsp_tuser,  // length_error
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_KEYX  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   localparam logic [3:0] LAST_ROUND = 4'(aescbc_pkg::ROUNDS);

   logic [2:0]   state_ff, state_in;
   logic         dir_ff, keys_ready_ff;
   logic [63:0]  key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic [127:0] rkey_ff [aescbc_pkg::NUM_KEYS];
   logic [127:0] work_key_ff;
   logic [7:0]   rcon_ff;
   logic [3:0]   cnt_ff;
   logic [127:0] blk_ff, st_ff, chain_ff;
   logic         first_ff, last_ff, short_ff, pend_ff;
   logic [127:0] res_data_ff;
   logic [4:0]   res_bytes_ff;
   logic         res_last_ff, res_err_ff;
   logic         rsp_valid_ff;
   logic [135:0] rsp_data_ff;
   logic         rsp_last_ff, rsp_err_ff;

   logic         accept, bad, rsp_free;
   logic [4:0]   count;
   logic [4:0]   pad_len;
   logic [127:0] blk_in;
   logic [127:0] padded, cv, rk, round_out, key_next, dec_out;
   logic [7:0]   rcon_next, tail;
   logic [3:0]   kidx;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign count      = req_tdata[132:128];
   assign pad_len    = 5'd16 - count;
   assign bad        = (count > 5'd16) || ((count < 5'd16) && (dir_ff || !req_tlast));
   // byte 0 leads: high word sits in the low half of tdata
   assign blk_in     = {req_tdata[63:0], req_tdata[127:64]};

   // fill the tail of a short block with the pad length
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (5'(i) >= count) padded[127 - 8 * i -: 8] = {3'b000, pad_len};
         else                padded[127 - 8 * i -: 8] = blk_in[127 - 8 * i -: 8];
      end
   end

   assign cv   = first_ff ? {iv_hi_ff, iv_lo_ff} : chain_ff;
   assign kidx = (state_ff == S_START) ? (dir_ff ? LAST_ROUND : 4'd0) : cnt_ff;
   assign rk   = rkey_ff[kidx];
   assign dec_out = st_ff ^ chain_ff;
   assign tail    = dec_out[7:0];

   aescbc_round u_round (
      .state_in   (st_ff),
      .round_key  (rk),
      .inverse    (dir_ff),
      .final_round(dir_ff ? (cnt_ff == 4'd0) : (cnt_ff == LAST_ROUND)),
      .state_out  (round_out)
   );

   aescbc_keyexp u_keyexp (
      .key_prev (work_key_ff),
      .rcon     (rcon_ff),
      .key_next (key_next),
      .rcon_next(rcon_next)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (bad)                state_in = S_EMIT;
               else if (!keys_ready_ff) state_in = S_KEYX;
               else                    state_in = S_START;
            end
         end
         S_KEYX:  if (cnt_ff == LAST_ROUND) state_in = S_START;
         S_START: state_in = S_ROUND;
         S_ROUND: begin
            if (dir_ff ? (cnt_ff == 4'd0) : (cnt_ff == LAST_ROUND)) state_in = S_FIN;
         end
         S_FIN:   state_in = S_EMIT;
         S_EMIT:  if (rsp_free) state_in = pend_ff ? S_START : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         dir_ff        <= 1'b0;
         key_hi_ff     <= '0;
         key_lo_ff     <= '0;
         iv_hi_ff      <= '0;
         iv_lo_ff      <= '0;
         keys_ready_ff <= 1'b0;
         chain_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               aescbc_pkg::REG_DIRECTION: dir_ff <= csr_data[0];
               aescbc_pkg::REG_KEY_HIGH: begin
                  key_hi_ff     <= csr_data;
                  keys_ready_ff <= 1'b0;
               end
               aescbc_pkg::REG_KEY_LOW: begin
                  key_lo_ff     <= csr_data;
                  keys_ready_ff <= 1'b0;
               end
               aescbc_pkg::REG_IV_HIGH: iv_hi_ff <= csr_data;
               aescbc_pkg::REG_IV_LOW:  iv_lo_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == S_KEYX && cnt_ff == LAST_ROUND) keys_ready_ff <= 1'b1;
         if (state_ff == S_START && !dir_ff) chain_ff <= cv;
         if (state_ff == S_START && dir_ff)  chain_ff <= cv;
         if (state_ff == S_FIN) begin
            chain_ff <= dir_ff ? blk_ff : st_ff;
            pend_ff  <= !dir_ff && !short_ff && last_ff;
         end
         if (state_ff == S_EMIT && rsp_free) pend_ff <= 1'b0;
         // drop valid once taken, raise on a new load
         if (state_ff == S_EMIT && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         blk_ff       <= padded;
         first_ff     <= req_tuser;
         last_ff      <= req_tlast;
         short_ff     <= (count < 5'd16);
         res_data_ff  <= '0;
         res_bytes_ff <= '0;
         res_last_ff  <= req_tlast;
         res_err_ff   <= 1'b1;
         rkey_ff[0]   <= {key_hi_ff, key_lo_ff};
         work_key_ff  <= {key_hi_ff, key_lo_ff};
         rcon_ff      <= 8'h01;
         cnt_ff       <= 4'd1;
      end
      case (state_ff)
         S_KEYX: begin
            rkey_ff[cnt_ff] <= key_next;
            work_key_ff     <= key_next;
            rcon_ff         <= rcon_next;
            cnt_ff          <= cnt_ff + 4'd1;
         end
         S_START: begin
            st_ff  <= dir_ff ? (blk_ff ^ rk) : (blk_ff ^ cv ^ rk);
            cnt_ff <= dir_ff ? (LAST_ROUND - 4'd1) : 4'd1;
         end
         S_ROUND: begin
            st_ff <= round_out;
            if (dir_ff) cnt_ff <= cnt_ff - 4'd1;
            else        cnt_ff <= cnt_ff + 4'd1;
         end
         S_FIN: begin
            res_err_ff <= 1'b0;
            if (dir_ff) begin
               res_data_ff <= dec_out;
               res_last_ff <= last_ff;
               if (last_ff && tail >= 8'd1 && tail <= 8'd16)
                  res_bytes_ff <= 5'd16 - tail[4:0];
               else
                  res_bytes_ff <= 5'd16;
            end else begin
               res_data_ff  <= st_ff;
               res_last_ff  <= short_ff;
               res_bytes_ff <= 5'd16;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_data_ff <= {3'b000, res_bytes_ff, res_data_ff[63:0], res_data_ff[127:64]};
               rsp_last_ff <= res_last_ff;
               rsp_err_ff  <= res_err_ff;
               // queue the full padding block after a full final block
               if (pend_ff) begin
                  blk_ff   <= {16{8'h10}};
                  first_ff <= 1'b0;
                  short_ff <= 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ----- rtl/aescbc_keyexp.sv -----
// One step of the AES-128 key schedule: next round key from the previous one.
module aescbc_keyexp (
   input  logic [127:0] key_prev,
   input  logic [7:0]   rcon,
   output logic [127:0] key_next,
   output logic [7:0]   rcon_next
);

   logic [31:0] w0, w1, w2, w3, rot, sub, t, n0, n1, n2, n3;

   always_comb begin
      w0  = key_prev[127:96];
      w1  = key_prev[95:64];
      w2  = key_prev[63:32];
      w3  = key_prev[31:0];
      rot = {w3[23:0], w3[31:24]};
      sub = {aescbc_pkg::SBOX[rot[31:24]], aescbc_pkg::SBOX[rot[23:16]],
             aescbc_pkg::SBOX[rot[15:8]],  aescbc_pkg::SBOX[rot[7:0]]};
      t   = sub ^ {rcon, 24'h000000};
      n0  = w0 ^ t;
      n1  = w1 ^ n0;
      n2  = w2 ^ n1;
      n3  = w3 ^ n2;
      key_next  = {n0, n1, n2, n3};
      rcon_next = aescbc_pkg::xtime(rcon);
   end

endmodule

// ----- rtl/aescbc_round.sv -----
// One AES round, forward or inverse, applied to the working state.
module aescbc_round (
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   input  logic         inverse,
   input  logic         final_round,
   output logic [127:0] state_out
);

   logic [7:0] s   [16];
   logic [7:0] sh  [16];
   logic [7:0] sb  [16];
   logic [7:0] mx  [16];
   logic [7:0] ak  [16];
   logic [7:0] o   [16];

   always_comb begin
      for (int i = 0; i < 16; i++) s[i] = state_in[127 - 8 * i -: 8];
      if (!inverse) begin
         // sub bytes, shift rows, mix columns (not in the final round), add key
         for (int i = 0; i < 16; i++) sb[i] = aescbc_pkg::SBOX[s[i]];
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               sh[r + 4 * c] = sb[r + 4 * ((c + r) & 3)];
         for (int c = 0; c < 4; c++) begin
            mx[4*c]   = aescbc_pkg::gmul(sh[4*c], 8'd2) ^ aescbc_pkg::gmul(sh[4*c+1], 8'd3)
                        ^ sh[4*c+2] ^ sh[4*c+3];
            mx[4*c+1] = sh[4*c] ^ aescbc_pkg::gmul(sh[4*c+1], 8'd2)
                        ^ aescbc_pkg::gmul(sh[4*c+2], 8'd3) ^ sh[4*c+3];
            mx[4*c+2] = sh[4*c] ^ sh[4*c+1] ^ aescbc_pkg::gmul(sh[4*c+2], 8'd2)
                        ^ aescbc_pkg::gmul(sh[4*c+3], 8'd3);
            mx[4*c+3] = aescbc_pkg::gmul(sh[4*c], 8'd3) ^ sh[4*c+1] ^ sh[4*c+2]
                        ^ aescbc_pkg::gmul(sh[4*c+3], 8'd2);
         end
         for (int i = 0; i < 16; i++) begin
            ak[i] = (final_round ? sh[i] : mx[i]) ^ round_key[127 - 8 * i -: 8];
            o[i]  = ak[i];
         end
      end else begin
         // inverse shift rows, inverse sub bytes, add key, inverse mix columns (not in the final round)
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               sh[r + 4 * ((c + r) & 3)] = s[r + 4 * c];
         for (int i = 0; i < 16; i++) sb[i] = aescbc_pkg::INV_SBOX[sh[i]];
         for (int i = 0; i < 16; i++) ak[i] = sb[i] ^ round_key[127 - 8 * i -: 8];
         for (int c = 0; c < 4; c++) begin
            mx[4*c]   = aescbc_pkg::gmul(ak[4*c], 8'd14) ^ aescbc_pkg::gmul(ak[4*c+1], 8'd11)
                        ^ aescbc_pkg::gmul(ak[4*c+2], 8'd13) ^ aescbc_pkg::gmul(ak[4*c+3], 8'd9);
            mx[4*c+1] = aescbc_pkg::gmul(ak[4*c], 8'd9) ^ aescbc_pkg::gmul(ak[4*c+1], 8'd14)
                        ^ aescbc_pkg::gmul(ak[4*c+2], 8'd11) ^ aescbc_pkg::gmul(ak[4*c+3], 8'd13);
            mx[4*c+2] = aescbc_pkg::gmul(ak[4*c], 8'd13) ^ aescbc_pkg::gmul(ak[4*c+1], 8'd9)
                        ^ aescbc_pkg::gmul(ak[4*c+2], 8'd14) ^ aescbc_pkg::gmul(ak[4*c+3], 8'd11);
            mx[4*c+3] = aescbc_pkg::gmul(ak[4*c], 8'd11) ^ aescbc_pkg::gmul(ak[4*c+1], 8'd13)
                        ^ aescbc_pkg::gmul(ak[4*c+2], 8'd9) ^ aescbc_pkg::gmul(ak[4*c+3], 8'd14);
         end
         for (int i = 0; i < 16; i++) o[i] = final_round ? ak[i] : mx[i];
      end
      for (int i = 0; i < 16; i++) state_out[127 - 8 * i -: 8] = o[i];
   end

endmodule

// ----- rtl/aescbc_checker.sv -----
// Port-level checks for the CBC codec, bound to the top level.
module aescbc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("codec ready straight after a block transfer");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("length error result carries data");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind aes128_cbc_codec_pkcs_pad_top aescbc_checker u_aescbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
